// File: rtl/core/soi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// soi_pkg: shared types and constants for the spiral order index block
// matrix dimension limits, field widths and configuration register codes
// ----------------------------------------------------------------------------
package soi_pkg;

  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned OUT_W   = 21;
  // offset along one ring: up to about 2*(rows+cols)
  localparam int unsigned OFS_W   = DIM_W + 2;
  // rows plus cols, less twice the ring number
  localparam int unsigned SUM_W   = DIM_W + 1;
  // count of cells in the outer rings, 2*k*sum
  localparam int unsigned BEF_W   = DIM_W + SUM_W + 1;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [OFS_W-1:0] ofs_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [BEF_W-1:0] bef_t;
  typedef logic [OUT_W-1:0] idx_t;

  typedef enum logic [0:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_e;

  localparam dim_t MaxDim = DIM_W'(MAX_DIM);

endpackage
`default_nettype wire

// File: rtl/core/spiral_order_index_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spiral_order_index_top: clockwise spiral position of a matrix cell
// closed-form ring count plus side offset, four register stages
// ----------------------------------------------------------------------------
// result timing: an accepted query passes the stage registers v1_q, v2_q, v3_q and
//   v4_q before the result strobe and the result are presented
// throughput: one query per cycle, busy_o stays low; the receiver cannot stall
// stages: ring select, side offset, ring cell count multiply, final add
// reset: pipeline valid bits clear, num_rows and num_cols return to 1
module spiral_order_index_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // query channel
  input  wire logic              start_i,
  output      logic              busy_o,
  input  wire soi_pkg::dim_t     query_row_i,
  input  wire soi_pkg::dim_t     query_col_i,
  // result channel
  output      logic              result_valid_o,
  output      soi_pkg::idx_t     spiral_index_o,
  // configuration write channel
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire soi_pkg::cfg_reg_e cfg_index_i,
  input  wire soi_pkg::dim_t     cfg_data_i
);
  import soi_pkg::*;

  // configuration registers
  dim_t num_rows_q, num_cols_q;
  dim_t cfg_sat;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign cfg_sat     = (cfg_data_i > MaxDim) ? MaxDim : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DIM_W'(1);
      num_cols_q <= DIM_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_NUM_ROWS: num_rows_q <= cfg_sat;
        REG_NUM_COLS: num_cols_q <= cfg_sat;
        default: ;
      endcase
    end
  end

  // stage 1: range check and ring number
  logic acc;
  dim_t dist_top, dist_left, dist_bot, dist_right, min_a, min_b;
  logic inside_d1;
  dim_t ring_d1;

  assign acc = start_i && !busy_o;

  always_comb begin
    dist_top   = query_row_i - DIM_W'(1);
    dist_left  = query_col_i - DIM_W'(1);
    dist_bot   = num_rows_q - query_row_i;
    dist_right = num_cols_q - query_col_i;
    min_a      = (dist_top < dist_left) ? dist_top : dist_left;
    min_b      = (dist_bot < dist_right) ? dist_bot : dist_right;
    ring_d1    = (min_a < min_b) ? min_a : min_b;
    inside_d1  = (query_row_i != '0) && (query_col_i != '0) &&
                 (query_row_i <= num_rows_q) && (query_col_i <= num_cols_q);
  end

  logic v1_q, in1_q;
  dim_t row1_q, col1_q, ring1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    in1_q   <= inside_d1;
    row1_q  <= query_row_i;
    col1_q  <= query_col_i;
    ring1_q <= ring_d1;
  end

  // stage 2: ring size and offset along the side holding the cell
  dim_t ring2x, ring_h, ring_w;
  sum_t ring_sum_d2;
  ofs_t ofs_d2;
  ofs_t e_row, e_col, e_k, e_h, e_w, e_nr, e_nc;

  always_comb begin
    ring2x      = {ring1_q[DIM_W-2:0], 1'b0};
    ring_h      = num_rows_q - ring2x;
    ring_w      = num_cols_q - ring2x;
    ring_sum_d2 = SUM_W'(num_rows_q) + SUM_W'(num_cols_q) - SUM_W'(ring2x);
    e_row       = OFS_W'(row1_q);
    e_col       = OFS_W'(col1_q);
    e_k         = OFS_W'(ring1_q);
    e_h         = OFS_W'(ring_h);
    e_w         = OFS_W'(ring_w);
    e_nr        = OFS_W'(num_rows_q);
    e_nc        = OFS_W'(num_cols_q);
    if (row1_q == ring1_q + DIM_W'(1)) begin
      // top side, left to right
      ofs_d2 = e_col - e_k;
    end else if (col1_q == num_cols_q - ring1_q) begin
      // right side, downward
      ofs_d2 = e_w + e_row - e_k - OFS_W'(1);
    end else if (row1_q == num_rows_q - ring1_q) begin
      // bottom side, right to left
      ofs_d2 = e_w + e_h - OFS_W'(1) + e_nc - e_k - e_col;
    end else begin
      // left side, upward
      ofs_d2 = e_w + e_w + e_h - OFS_W'(2) + e_nr - e_k - e_row;
    end
  end

  logic v2_q, in2_q;
  dim_t ring2_q;
  sum_t ring_sum2_q;
  ofs_t ofs2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in2_q       <= in1_q;
    ring2_q     <= ring1_q;
    ring_sum2_q <= ring_sum_d2;
    ofs2_q      <= ofs_d2;
  end

  // stage 3: cells in the outer rings, 2*k*(rows+cols-2*k)
  bef_t before_d3;

  assign before_d3 = {(BEF_W-1)'(ring2_q) * (BEF_W-1)'(ring_sum2_q), 1'b0};

  logic v3_q, in3_q;
  bef_t before3_q;
  ofs_t ofs3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in3_q     <= in2_q;
    before3_q <= before_d3;
    ofs3_q    <= ofs2_q;
  end

  // stage 4: final add, zero outside the matrix
  bef_t pos_sum;
  idx_t index_d;

  assign pos_sum = before3_q + BEF_W'(ofs3_q);
  assign index_d = in3_q ? pos_sum[OUT_W-1:0] : '0;

  logic v4_q;
  idx_t index4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    index4_q <= index_d;
  end

  assign result_valid_o = v4_q;
  assign spiral_index_o = index4_q;

  // every accepted query produces exactly one result once it leaves the last stage register
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 result_valid_o)
    else $error("accepted query lost in pipeline");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, 4))
    else $error("result strobe without a query");

  a_dim_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_rows_q <= MaxDim) && (num_cols_q <= MaxDim))
    else $error("dimension register above limit");

endmodule
`default_nettype wire
